[rtl/bic_pkg.sv]
package bic_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int SW    = 80;
  localparam int MW    = 72;
  localparam int PW    = 36;
  localparam int CFW   = 27;
  localparam int KW    = 25;
  localparam int QI_W  = 33;
  localparam int DIV_W = 64 + QI_W;

  localparam logic [26:0] EPS_DIV = 27'd100000000;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  localparam logic [2:0] REG_GRAVITY  = 3'd0;
  localparam logic [2:0] REG_STEP     = 3'd1;
  localparam logic [2:0] REG_DRAG     = 3'd2;
  localparam logic [2:0] REG_BOUNCE   = 3'd3;
  localparam logic [2:0] REG_FRICTION = 3'd4;
  localparam logic [2:0] REG_SLIP     = 3'd5;
  localparam logic [2:0] REG_SCALE    = 3'd6;

  localparam logic [3:0] LOP_HOLD = 4'd0;
  localparam logic [3:0] LOP_VADD = 4'd1;
  localparam logic [3:0] LOP_DRAG = 4'd2;
  localparam logic [3:0] LOP_STEP = 4'd3;
  localparam logic [3:0] LOP_POS  = 4'd4;
  localparam logic [3:0] LOP_PUSH = 4'd5;
  localparam logic [3:0] LOP_PMUL = 4'd6;
  localparam logic [3:0] LOP_PROJ = 4'd7;
  localparam logic [3:0] LOP_RMUL = 4'd8;
  localparam logic [3:0] LOP_VNEW = 4'd9;

  typedef struct packed {
    logic [3:0] op;
    logic       dot_neg;
  } lane_ctl_t;

  localparam logic signed [SW-1:0] SAT_MAX = 80'sd2147483647;
  localparam logic signed [SW-1:0] SAT_MIN = -80'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/bic_div.sv]
module bic_div
  import bic_pkg::*;
#(
  parameter int DW = DIV_W,
  parameter int QW = FRAC_BITS_DEF + QI_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DW-1:0]              dvd,
  input  logic [DW-1:0]              dvs,
  input  logic [$clog2(QW+1)-1:0]    steps,
  output logic                       busy,
  output logic [QW-1:0]              quo
);

  localparam int CW = $clog2(QW+1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [DW:0]   dvs_r, dvs_nxt;
  logic          ge;
  logic [DW:0]   sub;

  assign ge  = rem_r >= dvs_r;
  assign sub = ge ? (rem_r - dvs_r) : rem_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      rem_nxt  = {1'b0, dvd};
      dvs_nxt  = {1'b0, dvs};
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = {sub[DW-1:0], 1'b0};
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

[rtl/bic_sqrt.sv]
module bic_sqrt
  import bic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] n_r, n_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_comb begin
    n_nxt   = n_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    if (start) begin
      n_nxt   = rad;
      res_nxt = '0;
      bit_nxt = 64'h4000_0000_0000_0000;
    end else if (bit_r != '0) begin
      if (n_r >= trial) begin
        n_nxt   = n_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else begin
      bit_r <= bit_nxt;
    end
    n_r   <= n_nxt;
    res_r <= res_nxt;
  end

  assign busy = bit_r != '0;
  assign root = res_r[31:0];

endmodule

[rtl/bic_lane.sv]
module bic_lane
  import bic_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lane_ctl_t               ctl,
  input  logic signed [31:0]      push,
  input  logic signed [31:0]      add_in,
  input  logic [16:0]             time_step,
  input  logic signed [CFW-1:0]   drag_f,
  input  logic signed [CFW-1:0]   kf_f,
  input  logic [16:0]             bounce,
  input  logic [QI_W-1:0]         qi,
  input  logic [FRAC_BITS-1:0]    fr,
  output logic signed [31:0]      pos,
  output logic signed [31:0]      vel,
  output logic [63:0]             pp,
  output logic [63:0]             vv,
  output logic signed [63:0]      vp
);

  logic signed [31:0]   pos_r, pos_nxt;
  logic signed [31:0]   vel_r, vel_nxt;
  logic signed [MW-1:0] m_r, m_nxt;
  logic signed [MW-1:0] n_r, n_nxt;
  logic signed [PW-1:0] proj_r, proj_nxt;
  logic [63:0]          pp_r, pp_nxt;
  logic [63:0]          vv_r, vv_nxt;
  logic signed [63:0]   vp_r, vp_nxt;

  logic [31:0]          ap;
  logic signed [MW-1:0] mul_drag, mul_step, mul_rest, mul_bnc;
  logic signed [MW-1:0] mul_pp, mul_vv, mul_vp;
  logic [MW-1:0]        mul_qi, mul_fr;
  logic signed [PW:0]   rest;
  logic [PW-1:0]        pmag;

  assign ap       = push[31] ? (~push + 32'd1) : push;
  assign mul_drag = MW'(vel_r) * MW'(drag_f);
  assign mul_step = MW'(vel_r) * MW'($signed({1'b0, time_step}));
  assign mul_pp   = MW'(push) * MW'(push);
  assign mul_vv   = MW'(vel_r) * MW'(vel_r);
  assign mul_vp   = MW'(vel_r) * MW'(push);
  assign mul_qi   = MW'(ap) * MW'(qi);
  assign mul_fr   = MW'(ap) * MW'(fr);
  assign rest     = (PW+1)'(vel_r) - (PW+1)'(proj_r);
  assign mul_rest = MW'(rest) * MW'(kf_f);
  assign mul_bnc  = MW'(proj_r) * MW'($signed({1'b0, bounce}));
  assign pmag     = PW'(m_r) + PW'(n_r >> FRAC_BITS);

  always_comb begin
    pos_nxt  = pos_r;
    vel_nxt  = vel_r;
    m_nxt    = m_r;
    n_nxt    = n_r;
    proj_nxt = proj_r;
    pp_nxt   = pp_r;
    vv_nxt   = vv_r;
    vp_nxt   = vp_r;
    case (ctl.op)
      LOP_VADD: begin
        vel_nxt = sat32(SW'(vel_r) + SW'(add_in));
      end
      LOP_DRAG: begin
        vel_nxt = sat32(SW'(mul_drag >>> FRAC_BITS));
      end
      LOP_STEP: begin
        m_nxt = MW'(sat32(SW'(mul_step >>> FRAC_BITS)));
      end
      LOP_POS: begin
        pos_nxt = sat32(SW'(pos_r) + SW'(m_r));
      end
      LOP_PUSH: begin
        pos_nxt = sat32(SW'(pos_r) + SW'(push));
        pp_nxt  = mul_pp[63:0];
        vv_nxt  = mul_vv[63:0];
        vp_nxt  = mul_vp[63:0];
      end
      LOP_PMUL: begin
        m_nxt = $signed(mul_qi);
        n_nxt = $signed(mul_fr);
      end
      LOP_PROJ: begin
        proj_nxt = (push[31] != ctl.dot_neg) ? -$signed(pmag) : $signed(pmag);
      end
      LOP_RMUL: begin
        m_nxt = mul_rest;
        n_nxt = mul_bnc;
      end
      LOP_VNEW: begin
        vel_nxt = sat32(SW'(m_r >>> FRAC_BITS) - SW'(n_r >>> FRAC_BITS));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      vel_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      vel_r <= vel_nxt;
    end
    m_r    <= m_nxt;
    n_r    <= n_nxt;
    proj_r <= proj_nxt;
    pp_r   <= pp_nxt;
    vv_r   <= vv_nxt;
    vp_r   <= vp_nxt;
  end

  assign pos = pos_r;
  assign vel = vel_r;
  assign pp  = pp_r;
  assign vv  = vv_r;
  assign vp  = vp_r;

endmodule

[rtl/body_integrate_and_collide.sv]
// One rigid body integrated in signed fixed point with FRAC_BITS fraction bits. Each request
// on the input stream (tuser 0 tick, 1 collision push) gives exactly one result on the output
// stream, and a new request is taken only after the previous one has left the datapath. A
// tick adds gravity, applies drag and steps the position; a push too small to count is
// flagged as ignored. A full push waits on the shared restoring divider (one quotient bit
// per cycle) for the projection, and with slip_speed nonzero first on the square root (one
// result bit per step) and the friction ratio on that divider. Registers are written
// through the cfg port by the user only while the block is idle; the block has no check.
module body_integrate_and_collide
  import bic_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // push_x, push_y, push_z
  input  logic [0:0]   in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  output logic [0:0]   out_tuser,  // push_ignored
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int QW = FRAC_BITS + QI_W;
  localparam int CW = $clog2(QW + 1);
  localparam logic [CFW-1:0] ONE = CFW'(1) << FRAC_BITS;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_G0     = 5'd1;
  localparam logic [4:0] S_G1     = 5'd2;
  localparam logic [4:0] S_TVADD  = 5'd3;
  localparam logic [4:0] S_TDRAG  = 5'd4;
  localparam logic [4:0] S_TSTEP  = 5'd5;
  localparam logic [4:0] S_TPOS   = 5'd6;
  localparam logic [4:0] S_PPUSH  = 5'd7;
  localparam logic [4:0] S_PSUM   = 5'd8;
  localparam logic [4:0] S_PTHR   = 5'd9;
  localparam logic [4:0] S_SQGO   = 5'd10;
  localparam logic [4:0] S_SQWAIT = 5'd11;
  localparam logic [4:0] S_KNUM   = 5'd12;
  localparam logic [4:0] S_KGO    = 5'd13;
  localparam logic [4:0] S_KWAIT  = 5'd14;
  localparam logic [4:0] S_KMUL   = 5'd15;
  localparam logic [4:0] S_PGO    = 5'd16;
  localparam logic [4:0] S_PWAIT  = 5'd17;
  localparam logic [4:0] S_PMUL   = 5'd18;
  localparam logic [4:0] S_PPROJ  = 5'd19;
  localparam logic [4:0] S_PRMUL  = 5'd20;
  localparam logic [4:0] S_PVNEW  = 5'd21;
  localparam logic [4:0] S_DONE   = 5'd22;

  logic [4:0] state_r, state_nxt;

  logic signed [31:0] grav_r;
  logic [16:0]        tstep_r, drag_r, bounce_r, fric_r;
  logic [30:0]        slip_r;
  logic [24:0]        scale_r;
  logic [24:0]        scale_eff;

  logic               op_r;
  logic signed [31:0] push_r [3];
  logic signed [31:0] ga_r, ga_nxt, dv_r, dv_nxt;
  logic [63:0]        magsq_r, magsq_nxt, speedsq_r, speedsq_nxt, adot_r, adot_nxt;
  logic               dneg_r, dneg_nxt;
  logic [55:0]        slipd_r, slipd_nxt;
  logic [63:0]        num_r, num_nxt, den_r, den_nxt;
  logic [KW-1:0]      kf_r, kf_nxt;
  logic               ign_r, ign_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [191:0]       out_data_r, out_data_nxt;
  logic               out_user_r, out_user_nxt;

  logic signed [CFW-1:0] drag_f, kf_f;
  logic signed [SW-1:0]  ga_prod, dv_prod;
  logic signed [65:0]    dot_sum;
  logic [FRAC_BITS+26:0] thr_prod, thr_lim;
  logic                  thr_small;
  logic [FRAC_BITS+19:0] kf_prod;
  logic [FRAC_BITS+19:0] kf_shift;
  logic [63:0]           s_val;

  lane_ctl_t          ctl;
  logic signed [31:0] l_pos [3];
  logic signed [31:0] l_vel [3];
  logic [63:0]        l_pp [3];
  logic [63:0]        l_vv [3];
  logic signed [63:0] l_vp [3];

  logic               sq_start, sq_busy;
  logic [31:0]        sq_root;
  logic               dv_start, div_busy;
  logic [DIV_W-1:0]   div_dvd, div_dvs;
  logic [CW-1:0]      div_steps;
  logic [QW-1:0]      div_quo;

  assign cfg_ready = 1'b1;
  assign in_tready = state_r == S_IDLE;
  assign scale_eff = (scale_r == '0) ? 25'd1 : scale_r;

  assign drag_f = $signed(ONE) - $signed(CFW'(drag_r));
  assign kf_f   = $signed(ONE) - $signed(CFW'(kf_r));

  assign ga_prod = SW'(grav_r) * SW'($signed({1'b0, scale_eff}));
  assign dv_prod = SW'(ga_r) * SW'($signed({1'b0, tstep_r}));
  assign dot_sum = 66'(l_vp[0]) + 66'(l_vp[1]) + 66'(l_vp[2]);

  assign thr_small = (magsq_r >> FRAC_BITS) == '0;
  assign thr_prod  = (FRAC_BITS+27)'(magsq_r[FRAC_BITS-1:0]) * (FRAC_BITS+27)'(EPS_DIV);
  assign thr_lim   = (FRAC_BITS+27)'({scale_eff, {FRAC_BITS{1'b0}}});

  assign s_val    = 64'(sq_root) << FRAC_BITS;
  assign kf_prod  = (FRAC_BITS+20)'(fric_r) * (FRAC_BITS+20)'(div_quo[FRAC_BITS+2:0]);
  assign kf_shift = kf_prod >> FRAC_BITS;

  assign sq_start = state_r == S_SQGO;
  assign dv_start = (state_r == S_KGO) || (state_r == S_PGO);

  always_comb begin
    if (state_r == S_KGO) begin
      div_dvd   = DIV_W'(num_r);
      div_dvs   = DIV_W'(den_r) << 2;
      div_steps = CW'(FRAC_BITS + 3);
    end else begin
      div_dvd   = DIV_W'(adot_r);
      div_dvs   = DIV_W'(magsq_r) << (QI_W - 1);
      div_steps = CW'(FRAC_BITS + QI_W);
    end
  end

  always_comb begin
    ctl.dot_neg = dneg_r;
    case (state_r)
      S_TVADD: ctl.op = LOP_VADD;
      S_TDRAG: ctl.op = LOP_DRAG;
      S_TSTEP: ctl.op = LOP_STEP;
      S_TPOS:  ctl.op = LOP_POS;
      S_PPUSH: ctl.op = LOP_PUSH;
      S_PMUL:  ctl.op = LOP_PMUL;
      S_PPROJ: ctl.op = LOP_PROJ;
      S_PRMUL: ctl.op = LOP_RMUL;
      S_PVNEW: ctl.op = LOP_VNEW;
      default: ctl.op = LOP_HOLD;
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    bic_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .push     (push_r[g]),
      .add_in   ((g == 1) ? dv_r : 32'sd0),
      .time_step(tstep_r),
      .drag_f   (drag_f),
      .kf_f     (kf_f),
      .bounce   (bounce_r),
      .qi       (div_quo[FRAC_BITS +: QI_W]),
      .fr       (div_quo[FRAC_BITS-1:0]),
      .pos      (l_pos[g]),
      .vel      (l_vel[g]),
      .pp       (l_pp[g]),
      .vv       (l_vv[g]),
      .vp       (l_vp[g])
    );
  end

  bic_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .rad  (speedsq_r),
    .busy (sq_busy),
    .root (sq_root)
  );

  bic_div #(
    .DW(DIV_W),
    .QW(QW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(dv_start),
    .dvd  (div_dvd),
    .dvs  (div_dvs),
    .steps(div_steps),
    .busy (div_busy),
    .quo  (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    ga_nxt        = ga_r;
    dv_nxt        = dv_r;
    magsq_nxt     = magsq_r;
    speedsq_nxt   = speedsq_r;
    adot_nxt      = adot_r;
    dneg_nxt      = dneg_r;
    slipd_nxt     = slipd_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    kf_nxt        = kf_r;
    ign_nxt       = ign_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ign_nxt   = 1'b0;
          state_nxt = (in_tuser[0] == OP_PUSH) ? S_PPUSH : S_G0;
        end
      end
      S_G0: begin
        ga_nxt    = sat32(ga_prod >>> FRAC_BITS);
        state_nxt = S_G1;
      end
      S_G1: begin
        dv_nxt    = sat32(dv_prod >>> FRAC_BITS);
        state_nxt = S_TVADD;
      end
      S_TVADD: state_nxt = S_TDRAG;
      S_TDRAG: state_nxt = S_TSTEP;
      S_TSTEP: state_nxt = S_TPOS;
      S_TPOS:  state_nxt = S_DONE;
      S_PPUSH: state_nxt = S_PSUM;
      S_PSUM: begin
        magsq_nxt   = l_pp[0] + l_pp[1] + l_pp[2];
        speedsq_nxt = l_vv[0] + l_vv[1] + l_vv[2];
        dneg_nxt    = dot_sum[65];
        adot_nxt    = dot_sum[65] ? 64'(-dot_sum) : dot_sum[63:0];
        slipd_nxt   = 56'(slip_r) * 56'(scale_eff);
        state_nxt   = S_PTHR;
      end
      S_PTHR: begin
        kf_nxt = KW'(fric_r);
        if (thr_small && (thr_prod < thr_lim)) begin
          ign_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (slip_r != '0) begin
          state_nxt = S_SQGO;
        end else begin
          state_nxt = S_PGO;
        end
      end
      S_SQGO: state_nxt = S_SQWAIT;
      S_SQWAIT: begin
        if (!sq_busy) begin
          state_nxt = S_KNUM;
        end
      end
      S_KNUM: begin
        num_nxt   = s_val + {6'd0, slipd_r, 2'b00} + 64'(slipd_r);
        den_nxt   = s_val + 64'(slipd_r);
        state_nxt = S_KGO;
      end
      S_KGO: state_nxt = S_KWAIT;
      S_KWAIT: begin
        if (!div_busy) begin
          state_nxt = S_KMUL;
        end
      end
      S_KMUL: begin
        kf_nxt    = (kf_shift > (FRAC_BITS+20)'(ONE)) ? KW'(ONE) : KW'(kf_shift);
        state_nxt = S_PGO;
      end
      S_PGO: state_nxt = S_PWAIT;
      S_PWAIT: begin
        if (!div_busy) begin
          state_nxt = S_PMUL;
        end
      end
      S_PMUL:  state_nxt = S_PPROJ;
      S_PPROJ: state_nxt = S_PRMUL;
      S_PRMUL: state_nxt = S_PVNEW;
      S_PVNEW: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {l_vel[2], l_vel[1], l_vel[0], l_pos[2], l_pos[1], l_pos[0]};
          out_user_nxt  = ign_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      grav_r      <= '0;
      tstep_r     <= 17'd1092;
      drag_r      <= '0;
      bounce_r    <= '0;
      fric_r      <= '0;
      slip_r      <= '0;
      scale_r     <= 25'd65536;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_GRAVITY:  grav_r   <= cfg_data;
          REG_STEP:     tstep_r  <= cfg_data[16:0];
          REG_DRAG:     drag_r   <= cfg_data[16:0];
          REG_BOUNCE:   bounce_r <= cfg_data[16:0];
          REG_FRICTION: fric_r   <= cfg_data[16:0];
          REG_SLIP:     slip_r   <= cfg_data[30:0];
          REG_SCALE:    scale_r  <= cfg_data[24:0];
          default: begin
          end
        endcase
      end
    end
    if (in_tvalid && in_tready) begin
      op_r      <= in_tuser[0];
      push_r[0] <= in_tuser[0] ? in_tdata[31:0]  : 32'sd0;
      push_r[1] <= in_tuser[0] ? in_tdata[63:32] : 32'sd0;
      push_r[2] <= in_tuser[0] ? in_tdata[95:64] : 32'sd0;
    end
    ga_r       <= ga_nxt;
    dv_r       <= dv_nxt;
    magsq_r    <= magsq_nxt;
    speedsq_r  <= speedsq_nxt;
    adot_r     <= adot_nxt;
    dneg_r     <= dneg_nxt;
    slipd_r    <= slipd_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    kf_r       <= kf_nxt;
    ign_r      <= ign_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while another is in flight");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sq_busy && div_busy))
    else $error("square root and divider busy together");

  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!sq_busy && !div_busy))
    else $error("iterative unit busy while idle");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_tvalid || out_tready)) |=> (out_tvalid && in_tready))
    else $error("finished request not presented");

  a_tick_not_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !op_r) |-> !ign_r)
    else $error("tick flagged as ignored push");

endmodule
